/* sv/e2r_pkg.sv */
`default_nettype none
package e2r_pkg;
  localparam int WFRAC = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;

  typedef logic signed [CW-1:0] wval_t;

  function automatic wval_t atan_q30(input logic [4:0] i);
    wval_t r;
    r = '0;
    case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd66890614;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/e2r_if.sv */
`default_nettype none
interface e2r_if #(parameter int W = 16) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/e2r_mul.sv */
`default_nettype none
// registered q30 product with round: floor((a*b + 2^29) >> 30)
module e2r_mul (
  input  wire logic clk,
  input  wire logic en,
  input  wire e2r_pkg::wval_t a,
  input  wire e2r_pkg::wval_t b,
  output e2r_pkg::wval_t p_r
);
  logic signed [2*e2r_pkg::CW-1:0] prod;
  logic signed [2*e2r_pkg::CW-1:0] rnd;
  assign prod = a * b;
  assign rnd = prod + (68'sd1 <<< (e2r_pkg::WFRAC - 1));
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= e2r_pkg::wval_t'(rnd >>> e2r_pkg::WFRAC);
    end
  end
endmodule
`default_nettype wire

/* sv/euler_to_rotation_matrix_top.sv */
`default_nettype none
// stages from input beat to output beat: fold, 30 cordic steps, unfold, two product
// stages, output stage; throughput: one beat per cycle unless the output stalls
// each cordic step and each product has its own stage
// all stages advance together when the output register is free or taken
// reset clears the stage valid bits only; data registers are not reset
module euler_to_rotation_matrix_top #(
  parameter int ANGLE_BITS = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input wire logic clk,
  input wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [ANGLE_BITS-1:0] in_roll_angle,
  input  wire logic [ANGLE_BITS-1:0] in_pitch_angle,
  input  wire logic [ANGLE_BITS-1:0] in_yaw_angle,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [OUT_FRAC_BITS+1:0] out_m00,
  output logic [OUT_FRAC_BITS+1:0] out_m01,
  output logic [OUT_FRAC_BITS+1:0] out_m02,
  output logic [OUT_FRAC_BITS+1:0] out_m10,
  output logic [OUT_FRAC_BITS+1:0] out_m11,
  output logic [OUT_FRAC_BITS+1:0] out_m12,
  output logic [OUT_FRAC_BITS+1:0] out_m20,
  output logic [OUT_FRAC_BITS+1:0] out_m21,
  output logic [OUT_FRAC_BITS+1:0] out_m22
);
  localparam int N = e2r_pkg::CORDIC_STEPS;
  localparam int CW = e2r_pkg::CW;
  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int SH = e2r_pkg::WFRAC - OUT_FRAC_BITS;
  localparam int NST = N + 4;

  logic adv;
  logic [NST:0] vld_r;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NST];

  // valid bits shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:0], in_valid};
    end
  end

  logic [ANGLE_BITS-1:0] raw [3];
  assign raw[0] = in_roll_angle;
  assign raw[1] = in_pitch_angle;
  assign raw[2] = in_yaw_angle;

  e2r_pkg::wval_t x_r [3][N+1];
  e2r_pkg::wval_t y_r [3][N+1];
  e2r_pkg::wval_t z_r [3][N+1];
  logic flip_r [3][N+1];
  e2r_pkg::wval_t s_r [3];
  e2r_pkg::wval_t c_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    e2r_pkg::wval_t zin;
    assign zin = e2r_pkg::wval_t'($signed(raw[a])) <<< (e2r_pkg::WFRAC + 3 - ANGLE_BITS);
    // quadrant fold into [-pi/2, pi/2]
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[a][0] <= e2r_pkg::CORDIC_GAIN;
        y_r[a][0] <= '0;
        if (zin > e2r_pkg::HALF_PI_Q30) begin
          z_r[a][0] <= zin - e2r_pkg::PI_Q30;
          flip_r[a][0] <= 1'b1;
        end else if (zin < -e2r_pkg::HALF_PI_Q30) begin
          z_r[a][0] <= zin + e2r_pkg::PI_Q30;
          flip_r[a][0] <= 1'b1;
        end else begin
          z_r[a][0] <= zin;
          flip_r[a][0] <= 1'b0;
        end
      end
    end
    // one cordic micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_st
      e2r_pkg::wval_t dx, dy, at;
      assign dx = y_r[a][i] >>> i;
      assign dy = x_r[a][i] >>> i;
      assign at = e2r_pkg::atan_q30(5'(i));
      always_ff @(posedge clk) begin
        if (adv) begin
          flip_r[a][i+1] <= flip_r[a][i];
          if (!z_r[a][i][CW-1]) begin
            x_r[a][i+1] <= x_r[a][i] - dx;
            y_r[a][i+1] <= y_r[a][i] + dy;
            z_r[a][i+1] <= z_r[a][i] - at;
          end else begin
            x_r[a][i+1] <= x_r[a][i] + dx;
            y_r[a][i+1] <= y_r[a][i] - dy;
            z_r[a][i+1] <= z_r[a][i] + at;
          end
        end
      end
    end
    // undo the fold
    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[a] <= flip_r[a][N] ? -y_r[a][N] : y_r[a][N];
        c_r[a] <= flip_r[a][N] ? -x_r[a][N] : x_r[a][N];
      end
    end
  end

  // first product stage
  e2r_pkg::wval_t cysp, sysp, p00, p10, p21, p22, psycr, psysr, pcycr, pcysr;
  e2r_pkg::wval_t sr1_r, cr1_r, sp1_r;
  e2r_mul u_m0 (.clk, .en(adv), .a(c_r[2]), .b(s_r[1]), .p_r(cysp));
  e2r_mul u_m1 (.clk, .en(adv), .a(s_r[2]), .b(s_r[1]), .p_r(sysp));
  e2r_mul u_m2 (.clk, .en(adv), .a(c_r[2]), .b(c_r[1]), .p_r(p00));
  e2r_mul u_m3 (.clk, .en(adv), .a(s_r[2]), .b(c_r[1]), .p_r(p10));
  e2r_mul u_m4 (.clk, .en(adv), .a(c_r[1]), .b(s_r[0]), .p_r(p21));
  e2r_mul u_m5 (.clk, .en(adv), .a(c_r[1]), .b(c_r[0]), .p_r(p22));
  e2r_mul u_m6 (.clk, .en(adv), .a(s_r[2]), .b(c_r[0]), .p_r(psycr));
  e2r_mul u_m7 (.clk, .en(adv), .a(s_r[2]), .b(s_r[0]), .p_r(psysr));
  e2r_mul u_m8 (.clk, .en(adv), .a(c_r[2]), .b(c_r[0]), .p_r(pcycr));
  e2r_mul u_m9 (.clk, .en(adv), .a(c_r[2]), .b(s_r[0]), .p_r(pcysr));
  always_ff @(posedge clk) begin
    if (adv) begin
      sr1_r <= s_r[0];
      cr1_r <= c_r[0];
      sp1_r <= s_r[1];
    end
  end

  // second product stage
  e2r_pkg::wval_t q01, q02, q11, q12;
  e2r_pkg::wval_t v00_r, v10_r, v20_r, v21_r, v22_r;
  e2r_pkg::wval_t b01_r, b02_r, b11_r, b12_r;
  e2r_mul u_n0 (.clk, .en(adv), .a(cysp), .b(sr1_r), .p_r(q01));
  e2r_mul u_n1 (.clk, .en(adv), .a(cysp), .b(cr1_r), .p_r(q02));
  e2r_mul u_n2 (.clk, .en(adv), .a(sysp), .b(sr1_r), .p_r(q11));
  e2r_mul u_n3 (.clk, .en(adv), .a(sysp), .b(cr1_r), .p_r(q12));
  always_ff @(posedge clk) begin
    if (adv) begin
      v00_r <= p00;
      v10_r <= p10;
      v20_r <= -sp1_r;
      v21_r <= p21;
      v22_r <= p22;
      b01_r <= psycr;
      b02_r <= psysr;
      b11_r <= pcycr;
      b12_r <= pcysr;
    end
  end

  function automatic logic [OW-1:0] to_out(input e2r_pkg::wval_t v);
    logic signed [CW:0] t;
    logic signed [CW:0] lim;
    t = {v[CW-1], v};
    if (SH > 0) t = (t + ((CW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    lim = (CW+1)'(1) <<< OUT_FRAC_BITS;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[OW-1:0];
  endfunction

  // sum, round and saturate into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_m00 <= to_out(v00_r);
      out_m01 <= to_out(q01 - b01_r);
      out_m02 <= to_out(q02 + b02_r);
      out_m10 <= to_out(v10_r);
      out_m11 <= to_out(q11 + b11_r);
      out_m12 <= to_out(q12 - b12_r);
      out_m20 <= to_out(v20_r);
      out_m21 <= to_out(v21_r);
      out_m22 <= to_out(v22_r);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_m01))
    else $error("result dropped under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipe stalled with free output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("beat lost at entry");
endmodule
`default_nettype wire

/* sim/euler_to_rotation_matrix_top_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module euler_to_rotation_matrix_top_tb;

  localparam int AW = 16;
  localparam int MW = 16;
  localparam int ONE = 16384;
  localparam int HALF_PI_CODE = 12868;
  localparam int PI_CODE = 25736;
  localparam int PIPE_CYCLES = 35;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint ARCTAN_Q30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 66890614,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 8, 4, 2
  };

  typedef logic [8:0][MW-1:0] rot_mat_t;

  logic clk;
  logic rst_n;
  e2r_if #(.W(3*AW)) angle_ch (.clk(clk));
  e2r_if #(.W(9*MW)) mat_ch (.clk(clk));

  rot_mat_t pending_mats[$];
  int mismatches;
  int cycles;
  bit no_idle;
  int stall_left;

  euler_to_rotation_matrix_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(angle_ch.valid),
    .in_ready(angle_ch.ready),
    .in_roll_angle(angle_ch.data[3*AW-1:2*AW]),
    .in_pitch_angle(angle_ch.data[2*AW-1:AW]),
    .in_yaw_angle(angle_ch.data[AW-1:0]),
    .out_valid(mat_ch.valid),
    .out_ready(mat_ch.ready),
    .out_m00(mat_ch.data[0*MW +: MW]),
    .out_m01(mat_ch.data[1*MW +: MW]),
    .out_m02(mat_ch.data[2*MW +: MW]),
    .out_m10(mat_ch.data[3*MW +: MW]),
    .out_m11(mat_ch.data[4*MW +: MW]),
    .out_m12(mat_ch.data[5*MW +: MW]),
    .out_m20(mat_ch.data[6*MW +: MW]),
    .out_m21(mat_ch.data[7*MW +: MW]),
    .out_m22(mat_ch.data[8*MW +: MW])
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // sine and cosine in q.30 via folded cordic
  function automatic void sincos_q30(input logic [AW-1:0] code, output longint s,
                                     output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(code)) * 64'sd131072;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // round to q1.14 and clamp to +-1
  function automatic logic [MW-1:0] to_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r[MW-1:0];
  endfunction

  function automatic rot_mat_t rotation_from_euler(input logic [AW-1:0] roll,
                                                   input logic [AW-1:0] pitch,
                                                   input logic [AW-1:0] yaw);
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    rot_mat_t m;
    sincos_q30(roll, sr, cr);
    sincos_q30(pitch, sp, cp);
    sincos_q30(yaw, sy, cy);
    cysp = mul_q30(cy, sp);
    sysp = mul_q30(sy, sp);
    m[0] = to_q14(mul_q30(cy, cp));
    m[1] = to_q14(mul_q30(cysp, sr) - mul_q30(sy, cr));
    m[2] = to_q14(mul_q30(cysp, cr) + mul_q30(sy, sr));
    m[3] = to_q14(mul_q30(sy, cp));
    m[4] = to_q14(mul_q30(sysp, sr) + mul_q30(cy, cr));
    m[5] = to_q14(mul_q30(sysp, cr) - mul_q30(cy, sr));
    m[6] = to_q14(-sp);
    m[7] = to_q14(mul_q30(cp, sr));
    m[8] = to_q14(mul_q30(cp, cr));
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [MW-1:0] got,
                                 input logic [MW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what,
             $signed(got), $signed(want), cycles);
    mismatches++;
  endtask

  // send one angle beat, with an occasional idle burst before it
  task automatic send_angles(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                             input logic [AW-1:0] yaw);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.data <= {roll, pitch, yaw};
    do @(posedge clk); while (!angle_ch.ready);
    pending_mats.push_back(rotation_from_euler(roll, pitch, yaw));
  endtask

  // drop valid and wait for every expected result
  task automatic wait_drained();
    angle_ch.valid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
  endtask

  // result sink stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      mat_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 6);
      mat_ch.ready <= 1'b0;
    end else begin
      mat_ch.ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expected matrix
  always @(posedge clk) begin
    rot_mat_t want;
    if (rst_n && mat_ch.valid && mat_ch.ready) begin
      if (pending_mats.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycles);
        mismatches++;
      end else begin
        want = pending_mats.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (mat_ch.data[k*MW +: MW] !== want[k])
            report_mismatch($sformatf("m%0d%0d", k / 3, k % 3), mat_ch.data[k*MW +: MW],
                            want[k]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euler_to_rotation_matrix_top_tb failed");
      $finish;
    end
  end

  // zero, field extremes, fold boundaries and gimbal lock
  task automatic test_directed();
    int codes[10] = '{0, 32767, -32768, HALF_PI_CODE, HALF_PI_CODE + 1, -HALF_PI_CODE,
                      -HALF_PI_CODE - 1, PI_CODE, -PI_CODE, 1};
    send_angles(16'd0, 16'd0, 16'd0);
    for (int k = 0; k < 10; k++)
      send_angles(codes[k][AW-1:0], codes[(k + 3) % 10][AW-1:0], codes[(k + 7) % 10][AW-1:0]);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h1234, HALF_PI_CODE[AW-1:0], 16'h0567);
    send_angles(16'h1234, 16'(-HALF_PI_CODE), 16'hf567);
    send_angles(16'hffff, 16'hffff, 16'hffff);
  endtask

  function automatic logic [AW-1:0] pick_angle();
    int c;
    case ($urandom_range(0, 7))
      0: c = HALF_PI_CODE + $urandom_range(0, 6) - 3;
      1: c = -HALF_PI_CODE + $urandom_range(0, 6) - 3;
      2: c = $urandom_range(0, 6) - 3;
      default: c = $urandom_range(0, 65535);
    endcase
    return c[AW-1:0];
  endfunction

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++)
      send_angles(pick_angle(), pick_angle(), pick_angle());
  endtask

  // sender holds off until the pipeline has emptied
  task automatic test_drain_pause();
    wait_drained();
    repeat (3) send_angles(pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    rst_n <= 1'b0;
    angle_ch.valid <= 1'b0;
    angle_ch.data <= '0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_drain_pause();
    test_random(550);
    no_idle = 1'b1;
    test_random(200);
    wait_drained();
    repeat (PIPE_CYCLES + 5) @(posedge clk);
    if (mismatches == 0 && pending_mats.size() == 0)
      $display("euler_to_rotation_matrix_top_tb passed");
    else
      $display("euler_to_rotation_matrix_top_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
